/* sv/stbs_pkg.sv */
`timescale 1ns / 1ps

package stbs_pkg;

  // Default sizes for the top-level parameters.
  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int KEY_WIDTH_DEFAULT   = 8;

  // Fixed port widths.
  localparam int SIZE_W = 7;
  localparam int IDX_W  = 6;
  localparam int KEY_W  = 8;
  localparam int POS_W  = 6;
  localparam int REG_W  = 1;

  // Request kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [REG_W-1:0] REG_ORDER_DESC = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PROBE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // write the request key into the table
    logic init;         // open the search interval, capture the target
    logic step;         // narrow the interval after a miss on the probe
    logic finish_hit;   // capture found and the probe position
    logic finish_miss;  // capture a not-found answer
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;  // search interval holds no entry
    logic hit;    // probed entry equals the target
  } dp_status_t;

endpackage

/* sv/stbs_ram.sv */
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/stbs_ctrl.sv */
`timescale 1ns / 1ps

module stbs_ctrl import stbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       strobe
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.finish_hit | cmd.finish_miss;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_SEARCH) begin
            cmd.init   = 1'b1;
            state_next = ST_PROBE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.empty) begin
          cmd.finish_miss = 1'b1;
          state_next      = ST_IDLE;
        end else if (status.hit) begin
          cmd.finish_hit = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state == ST_PROBE);

endmodule

/* sv/stbs_datapath.sv */
`timescale 1ns / 1ps

module stbs_datapath import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_en,
  input  logic [REG_W-1:0]  reg_index,
  input  logic [SIZE_W-1:0] write_data,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [KEY_W-1:0]  key_value,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic              found,
  output logic [POS_W-1:0]  position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;

  logic [SIZE_W-1:0]    table_size;
  logic                 order_descending;
  logic [KEY_WIDTH-1:0] target;
  logic [CW-1:0]        first;
  logic [CW-1:0]        limit;

  logic [CW-1:0]        size_sat;
  logic [CW-1:0]        span;
  logic [CW-1:0]        mid_wide;
  logic [AW-1:0]        mid;
  logic [CW-1:0]        first_next;
  logic [CW-1:0]        limit_next;
  logic [CW-1:0]        span_next;
  logic [CW-1:0]        mid_next_wide;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 go_low;
  logic                 in_range;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size       <= '0;
      order_descending <= 1'b1;
    end else if (write_en) begin
      case (reg_index)
        REG_TABLE_SIZE: table_size       <= write_data;
        REG_ORDER_DESC: order_descending <= write_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the entry count to the table depth.
  assign size_sat = (SW'(table_size) > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                          : CW'(table_size);

  // Interval is [first, limit); probe the middle of it.
  assign span     = limit - first - CW'(1);
  assign mid_wide = first + (span >> 1);
  assign mid      = mid_wide[AW-1:0];

  // Move toward the lower half when the probe lies on the far side of the target.
  assign go_low = ((rd_data < target) == order_descending);

  always_comb begin
    first_next = first;
    limit_next = limit;
    if (cmd.init) begin
      first_next = '0;
      limit_next = size_sat;
    end else if (cmd.step) begin
      if (go_low) begin
        limit_next = mid_wide;
      end else begin
        first_next = mid_wide + CW'(1);
      end
    end
  end

  // Issue the next probe read so its data lands with the next interval.
  assign span_next     = limit_next - first_next - CW'(1);
  assign mid_next_wide = first_next + (span_next >> 1);

  always_ff @(posedge clk) begin
    first <= first_next;
    limit <= limit_next;
    if (cmd.init) begin
      target <= KEY_WIDTH'(key_value);
    end
    if (cmd.finish_hit) begin
      found    <= 1'b1;
      position <= POS_W'(mid);
    end else if (cmd.finish_miss) begin
      found    <= 1'b0;
      position <= '0;
    end
  end

  assign in_range = (32'(entry_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (cmd.load & in_range),
    .waddr (AW'(entry_index)),
    .wdata (KEY_WIDTH'(key_value)),
    .raddr (mid_next_wide[AW-1:0]),
    .rdata (rd_data)
  );

  assign status.empty = !(first < limit);
  assign status.hit   = (rd_data == target);

endmodule

/* sv/sorted_table_binary_search_unit.sv */
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// request   mode, entry_index, key_value            taken when start && !busy
// result    found, position                         valid for one cycle on strobe
// config    write_en, reg_index, write_data         written when write_en is high
//
// A load request writes its key into the table and keeps busy low; it produces no result.
// A search request raises busy and then probes the key RAM through its registered
// read port; a hit loads the result and strobe registers from the matching probe,
// a miss from the check that finds the search interval empty.
// Reset returns the size register to 0 and the order to descending; the key
// table is not cleared and an entry must be loaded before a search reads it.
// The result is never stalled: strobe lasts exactly one cycle.

module sorted_table_binary_search_unit import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              write_en,
  input  logic [REG_W-1:0]  reg_index,
  input  logic [SIZE_W-1:0] write_data,
  // request
  input  logic              start,
  output logic              busy,
  input  logic              mode,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [KEY_W-1:0]  key_value,
  // result
  output logic              strobe,
  output logic              found,
  output logic [POS_W-1:0]  position
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence requests: load in place, search one probe per cycle.
  stbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  // Hold the table, the interval bounds and the result registers.
  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .entry_index (entry_index),
    .key_value   (key_value),
    .cmd         (cmd),
    .status      (status),
    .found       (found),
    .position    (position)
  );

`ifndef ASSERT_OFF
  // A result only closes a search that was running.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a running search");

  // A miss reports position zero.
  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (strobe && !found) |-> (position == '0))
    else $error("miss with nonzero position");

  // An accepted search starts probing in the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_SEARCH) |=> busy)
    else $error("search request did not raise busy");

  // A load neither blocks nor produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_LOAD) |=> (!busy && !strobe))
    else $error("load request raised busy or a result");
`endif

endmodule
